[design/pftc_pkg.sv]
// shared constants, widths and the quarter-sine table for the perspective floor mapper
// no dependencies; used by pftc_div, pftc_wrap and perspective_floor_texcoord_core
package pftc_pkg;

    localparam int ANGLE_STEPS  = 1024;
    localparam int FAR_RATIO    = 20;
    localparam int TEX_DIM_MAX  = 4096;

    // angle index split: quadrant in the top two bits, table step below
    localparam int HEAD_W       = 10;
    localparam int QSTEP_W      = HEAD_W - 2;
    localparam int SIN_TAB_LAST = ANGLE_STEPS / 4;
    localparam int SIN_IDX_W    = QSTEP_W + 1;
    localparam int SIN_W        = 15;

    // reciprocal-depth divider: quotient z, Q.12
    localparam int NUM_W        = 21;
    localparam int DEN_W        = 21;
    localparam int Z_W          = 25;
    localparam int DIV_STAGES   = 5;
    localparam int DIV_STEPS    = Z_W / DIV_STAGES;
    localparam int DEN_BASE     = FAR_RATIO * 65536;
    localparam int DEN_STEP     = FAR_RATIO - 1;

    // texture wrap
    localparam int COORD_W      = 12;
    localparam int SIZE_W       = 13;
    localparam int PT_W         = 18;
    localparam int MAG_W        = 18;
    localparam int WRAP_STAGES  = 3;
    localparam int WRAP_STEPS   = MAG_W / WRAP_STAGES;

    typedef logic [SIN_W-1:0] t_sin_q14;
    typedef t_sin_q14 t_sin_tab [0:SIN_TAB_LAST];

    // sin(pi/2 * 4k / N) in Q1.14 by a Q30 taylor series, evaluated at elaboration
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned m;
        longint          sum;
        longint          r;
        for (int k = 0; k <= SIN_TAB_LAST; k++) begin
            m    = longint'(4 * k);
            // ANGLE_STEPS is 2^HEAD_W
            x    = (64'd1686629713 * m) >> HEAD_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int i = 1; i <= 9; i++) begin
                term = (term * x2) >> 30;
                // divide by (2i)(2i+1)
                case (i)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    7:       term = term / 64'd210;
                    8:       term = term / 64'd272;
                    default: term = term / 64'd342;
                endcase
                if ((i & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 32768) >>> 16;
            if (r > 16384) begin
                r = 16384;
            end
            tab[k] = t_sin_q14'(r);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

[design/pftc_div.sv]
// pipelined restoring divider for the line depth z = num * 2^20 / den
// depends on pftc_pkg; five quotient bits per stage, no stall
module pftc_div (
    input  logic                          i_clk,
    input  logic [pftc_pkg::NUM_W-1:0]    i_num,
    input  logic [pftc_pkg::DEN_W-1:0]    i_den,
    output logic [pftc_pkg::Z_W-1:0]      o_quo
);

    localparam int NS = pftc_pkg::DIV_STAGES;
    localparam int DW = pftc_pkg::DEN_W;
    localparam int ZW = pftc_pkg::Z_W;
    localparam int LO = pftc_pkg::NUM_W - ZW + 20;

    logic [DW-1:0] a_rem [0:NS-1];
    logic [ZW-1:0] a_low [0:NS-1];
    logic [ZW-1:0] a_quo [0:NS-1];
    logic [DW-1:0] a_den [0:NS-1];

    logic [DW-1:0] r_rem [0:NS-1];
    logic [ZW-1:0] r_low [0:NS-1];
    logic [ZW-1:0] r_quo [0:NS-1];
    logic [DW-1:0] r_den [0:NS-1];

    // bits above the quotient width of num*2^20 start as the remainder (below den)
    assign a_rem[0] = DW'(i_num[pftc_pkg::NUM_W-1:pftc_pkg::NUM_W-LO]);
    assign a_low[0] = {i_num[pftc_pkg::NUM_W-LO-1:0], 20'd0};
    assign a_quo[0] = '0;
    assign a_den[0] = i_den;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [DW-1:0] n_rem;
        logic [ZW-1:0] n_low;
        logic [ZW-1:0] n_quo;

        if (g > 0) begin : g_link
            assign a_rem[g] = r_rem[g-1];
            assign a_low[g] = r_low[g-1];
            assign a_quo[g] = r_quo[g-1];
            assign a_den[g] = r_den[g-1];
        end

        always_comb begin
            logic [DW:0] rem2;
            n_rem = a_rem[g];
            n_low = a_low[g];
            n_quo = a_quo[g];
            for (int s = 0; s < pftc_pkg::DIV_STEPS; s++) begin
                rem2  = {n_rem, n_low[ZW-1]};
                n_low = {n_low[ZW-2:0], 1'b0};
                if (rem2 >= {1'b0, a_den[g]}) begin
                    n_rem = DW'(rem2 - {1'b0, a_den[g]});
                    n_quo = {n_quo[ZW-2:0], 1'b1};
                end else begin
                    n_rem = rem2[DW-1:0];
                    n_quo = {n_quo[ZW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_low[g] <= n_low;
            r_quo[g] <= n_quo;
            r_den[g] <= a_den[g];
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

[design/pftc_wrap.sv]
// floored modulo of a signed texel coordinate by the clamped texture size
// depends on pftc_pkg; abs stage, three remainder stages, sign fix stage
module pftc_wrap (
    input  logic                              i_clk,
    input  logic signed [pftc_pkg::PT_W-1:0]  i_val,
    input  logic [pftc_pkg::SIZE_W-1:0]       i_size,
    output logic [pftc_pkg::COORD_W-1:0]      o_coord
);

    localparam int NS = pftc_pkg::WRAP_STAGES;
    localparam int SW = pftc_pkg::SIZE_W;
    localparam int MW = pftc_pkg::MAG_W;

    logic [SW-1:0] mod_m;

    always_comb begin
        if (i_size == '0) begin
            mod_m = SW'(1);
        end else if (i_size > SW'(pftc_pkg::TEX_DIM_MAX)) begin
            mod_m = SW'(pftc_pkg::TEX_DIM_MAX);
        end else begin
            mod_m = i_size;
        end
    end

    logic          r_neg0;
    logic [MW-1:0] r_mag0;

    always_ff @(posedge i_clk) begin
        r_neg0 <= i_val[pftc_pkg::PT_W-1];
        r_mag0 <= i_val[pftc_pkg::PT_W-1] ? MW'(-i_val) : MW'(i_val);
    end

    logic [SW-1:0] a_rem [0:NS-1];
    logic [MW-1:0] a_low [0:NS-1];
    logic          a_neg [0:NS-1];
    logic [SW-1:0] r_rem [0:NS-1];
    logic [MW-1:0] r_low [0:NS-1];
    logic          r_neg [0:NS-1];

    assign a_rem[0] = '0;
    assign a_low[0] = r_mag0;
    assign a_neg[0] = r_neg0;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [SW-1:0] n_rem;
        logic [MW-1:0] n_low;

        if (g > 0) begin : g_link
            assign a_rem[g] = r_rem[g-1];
            assign a_low[g] = r_low[g-1];
            assign a_neg[g] = r_neg[g-1];
        end

        always_comb begin
            logic [SW:0] rem2;
            n_rem = a_rem[g];
            n_low = a_low[g];
            for (int s = 0; s < pftc_pkg::WRAP_STEPS; s++) begin
                rem2  = {n_rem, n_low[MW-1]};
                n_low = {n_low[MW-2:0], 1'b0};
                if (rem2 >= {1'b0, mod_m}) begin
                    n_rem = SW'(rem2 - {1'b0, mod_m});
                end else begin
                    n_rem = rem2[SW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_low[g] <= n_low;
            r_neg[g] <= a_neg[g];
        end
    end

    logic [SW-1:0] fixed;

    // negative input with a nonzero remainder folds back into range
    always_comb begin
        if (r_neg[NS-1] && (r_rem[NS-1] != '0)) begin
            fixed = mod_m - r_rem[NS-1];
        end else begin
            fixed = r_rem[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_coord <= fixed[pftc_pkg::COORD_W-1:0];
    end

endmodule

[design/perspective_floor_texcoord_core.sv]
// top level of the mode-7 style floor texel mapper
// depends on pftc_pkg, pftc_div and pftc_wrap
//
// A beat is taken on every cycle in which start is high (busy stays low). Its texel
// coordinate is driven on o_tex_x/o_tex_y with o_strobe; one beat per cycle is sustained,
// and the receiver must take each result in its strobe cycle. The result passes through
// the input register, the depth divider (25 quotient bits, five per stage), the multiply,
// add and truncate stages and the texture wrap unit (abs, three remainder stages, fold).
// Registers are to be written through the cfg port only while no beat is in flight; the
// block itself does not enforce this. A heading write passes r_heading, then r_sin/r_cos.
module perspective_floor_texcoord_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       i_depth_frac,
    input  logic [15:0]                       i_lateral_frac,
    output logic                              o_strobe,
    output logic [pftc_pkg::COORD_W-1:0]      o_tex_x,
    output logic [pftc_pkg::COORD_W-1:0]      o_tex_y,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [23:0]                       i_cfg_data
);

    localparam logic [2:0] CFG_CAM_X   = 3'd0;
    localparam logic [2:0] CFG_CAM_Y   = 3'd1;
    localparam logic [2:0] CFG_HEADING = 3'd2;
    localparam logic [2:0] CFG_NEAR    = 3'd3;
    localparam logic [2:0] CFG_TEX_W   = 3'd4;
    localparam logic [2:0] CFG_TEX_H   = 3'd5;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    localparam int LAT = 14;
    localparam int DXD = pftc_pkg::DIV_STAGES;

    // configuration registers
    logic signed [23:0]               r_cam_x;
    logic signed [23:0]               r_cam_y;
    logic [pftc_pkg::HEAD_W-1:0]      r_heading;
    logic [15:0]                      r_near;
    logic [pftc_pkg::SIZE_W-1:0]      r_tex_w;
    logic [pftc_pkg::SIZE_W-1:0]      r_tex_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x   <= '0;
            r_cam_y   <= '0;
            r_heading <= '0;
            r_near    <= 16'd3456;
            r_tex_w   <= pftc_pkg::SIZE_W'(1024);
            r_tex_h   <= pftc_pkg::SIZE_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAM_X:   r_cam_x   <= i_cfg_data;
                CFG_CAM_Y:   r_cam_y   <= i_cfg_data;
                CFG_HEADING: r_heading <= i_cfg_data[pftc_pkg::HEAD_W-1:0];
                CFG_NEAR:    r_near    <= i_cfg_data[15:0];
                CFG_TEX_W:   r_tex_w   <= i_cfg_data[pftc_pkg::SIZE_W-1:0];
                CFG_TEX_H:   r_tex_h   <= i_cfg_data[pftc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sin/cos of the heading, Q1.14
    logic [pftc_pkg::QSTEP_W-1:0]    step_a;
    logic [pftc_pkg::SIN_IDX_W-1:0]  step_b;
    logic signed [15:0]              sin_a;
    logic signed [15:0]              sin_b;
    logic signed [15:0]              n_sin;
    logic signed [15:0]              n_cos;
    logic signed [15:0]              r_sin;
    logic signed [15:0]              r_cos;

    always_comb begin
        step_a = r_heading[pftc_pkg::QSTEP_W-1:0];
        step_b = pftc_pkg::SIN_IDX_W'(pftc_pkg::SIN_TAB_LAST) - {1'b0, step_a};
        sin_a  = $signed({1'b0, pftc_pkg::SIN_TAB[step_a]});
        sin_b  = $signed({1'b0, pftc_pkg::SIN_TAB[step_b]});
        case (r_heading[pftc_pkg::HEAD_W-1 -: 2])
            QUAD_I:   begin n_sin = sin_a;  n_cos = sin_b;  end
            QUAD_II:  begin n_sin = sin_b;  n_cos = -sin_a; end
            QUAD_III: begin n_sin = -sin_a; n_cos = -sin_b; end
            default:  begin n_sin = -sin_b; n_cos = sin_a;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    // valid bits travel with the beat
    logic [LAT-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    assign o_strobe = r_vld[LAT-1];

    // stage 0: denominator and lateral offset
    logic [pftc_pkg::DEN_W-1:0] r0_den;
    logic signed [16:0]         r0_w;

    always_ff @(posedge i_clk) begin
        r0_den <= pftc_pkg::DEN_W'(pftc_pkg::DEN_BASE)
                - pftc_pkg::DEN_W'(i_depth_frac * pftc_pkg::DEN_STEP);
        r0_w   <= $signed({i_lateral_frac, 1'b0}) - 17'sd65536;
    end

    logic [pftc_pkg::NUM_W-1:0] near_num;
    logic [pftc_pkg::Z_W-1:0]   z;

    assign near_num = pftc_pkg::NUM_W'(r_near * pftc_pkg::FAR_RATIO);

    pftc_div u_div (
        .i_clk (i_clk),
        .i_num (near_num),
        .i_den (r0_den),
        .o_quo (z)
    );

    // direction vector, Q.30, delayed to meet z
    logic signed [32:0] r_dx [0:DXD-1];
    logic signed [32:0] r_dy [0:DXD-1];

    always_ff @(posedge i_clk) begin
        r_dx[0] <= 33'(r0_w) * 33'(r_cos) - 33'($signed({r_sin, 16'd0}));
        r_dy[0] <= 33'($signed({r_cos, 16'd0})) + 33'(r0_w) * 33'(r_sin);
        for (int i = 1; i < DXD; i++) begin
            r_dx[i] <= r_dx[i-1];
            r_dy[i] <= r_dy[i-1];
        end
    end

    // z times direction, then camera offset, Q.42
    logic signed [58:0] r_mx;
    logic signed [58:0] r_my;
    logic signed [59:0] r_sx;
    logic signed [59:0] r_sy;

    always_ff @(posedge i_clk) begin
        r_mx <= 59'($signed({1'b0, z})) * 59'(r_dx[DXD-1]);
        r_my <= 59'($signed({1'b0, z})) * 59'(r_dy[DXD-1]);
        r_sx <= 60'($signed({r_cam_x, 34'd0})) + 60'(r_mx);
        r_sy <= 60'($signed({r_cam_y, 34'd0})) + 60'(r_my);
    end

    // truncate toward zero; y is negated
    logic signed [pftc_pkg::PT_W-1:0] tx;
    logic signed [pftc_pkg::PT_W-1:0] ty;
    logic signed [pftc_pkg::PT_W-1:0] r_px;
    logic signed [pftc_pkg::PT_W-1:0] r_py;

    always_comb begin
        tx = r_sx[59:42];
        ty = r_sy[59:42];
        if (r_sx[59] && (r_sx[41:0] != '0)) begin
            tx = tx + 18'sd1;
        end
        if (r_sy[59] && (r_sy[41:0] != '0)) begin
            ty = ty + 18'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= tx;
        r_py <= -ty;
    end

    pftc_wrap u_wrap_x (
        .i_clk   (i_clk),
        .i_val   (r_px),
        .i_size  (r_tex_w),
        .o_coord (o_tex_x)
    );

    pftc_wrap u_wrap_y (
        .i_clk   (i_clk),
        .i_val   (r_py),
        .i_size  (r_tex_h),
        .o_coord (o_tex_y)
    );

    // a strobe only ever follows an accepted beat by the full latency
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("strobe without matching accepted beat");

    // with a unit-square texture both coordinates are zero
    a_unit_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_tex_w == 13'd1 && r_tex_h == 13'd1) |-> (o_tex_x == '0 && o_tex_y == '0))
        else $error("unit texture gave nonzero coordinate");

    // cos and sin never both vanish
    a_trig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $stable(r_heading) |=> (r_sin != '0 || r_cos != '0))
        else $error("sin and cos both zero");

endmodule

[bench/testbench.sv]
// self-checking bench for perspective_floor_texcoord_core: directed corners, then random beats
// depends on pftc_pkg and the core; the texel predictor lives in the floor_map_board class below

typedef enum logic [2:0] {
    REG_CAM_X      = 3'd0,
    REG_CAM_Y      = 3'd1,
    REG_HEADING    = 3'd2,
    REG_NEAR_DEPTH = 3'd3,
    REG_TEX_WIDTH  = 3'd4,
    REG_TEX_HEIGHT = 3'd5,
    REG_SPARE_A    = 3'd6,
    REG_SPARE_B    = 3'd7
} t_reg_idx;

class floor_map_board;
    longint cam_x, cam_y;
    int unsigned heading, near_depth, tex_width, tex_height;
    logic [11:0] want_x [$];
    logic [11:0] want_y [$];
    int mismatches;

    function new();
        cam_x = 0; cam_y = 0; heading = 0; near_depth = 3456;
        tex_width = 1024; tex_height = 1024; mismatches = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [23:0] d);
        case (idx)
            REG_CAM_X:      cam_x = longint'(signed'(d));
            REG_CAM_Y:      cam_y = longint'(signed'(d));
            REG_HEADING:    heading = d[9:0];
            REG_NEAR_DEPTH: near_depth = d[15:0];
            REG_TEX_WIDTH:  tex_width = d[12:0];
            REG_TEX_HEIGHT: tex_height = d[12:0];
            default: ;
        endcase
    endfunction

    // sin(pi/2 * m / 1024) in Q1.14 via a Q30 series
    function longint qsine(longint unsigned m);
        longint unsigned x, x2, term;
        longint acc, r;
        x = (64'd1686629713 * m) / 64'd1024;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int i = 1; i <= 9; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        r = (acc + 32768) / 65536;
        if (r > 16384) r = 16384;
        return r;
    endfunction

    function logic [11:0] fold(longint p, int unsigned size);
        longint m, r;
        m = size;
        if (m < 1) m = 1;
        if (m > pftc_pkg::TEX_DIM_MAX) m = pftc_pkg::TEX_DIM_MAX;
        r = p % m;
        if (r < 0) r = r + m;
        return r[11:0];
    endfunction

    function void note_beat(logic [15:0] v, logic [15:0] u);
        longint unsigned q, quad, r;
        longint a, b, s, c, z, w, dx, dy, px, py;
        q = (heading % 1024) * 4;
        quad = q / 1024;
        r = q % 1024;
        a = qsine(r);
        b = qsine(1024 - r);
        case (quad & 3)
            0: begin s = a; c = b; end
            1: begin s = b; c = -a; end
            2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
        z = (longint'(near_depth) * 20 * (64'sd1 << 20)) / (20 * 65536 - longint'(v) * 19);
        w = 2 * longint'(u) - 65536;
        dx = w * c - 65536 * s;
        dy = 65536 * c + w * s;
        px = (cam_x * (64'sd1 << 34) + z * dx) / (64'sd1 << 42);
        py = (cam_y * (64'sd1 << 34) + z * dy) / (64'sd1 << 42);
        want_x.push_back(fold(px, tex_width));
        want_y.push_back(fold(-py, tex_height));
    endfunction

    function void check_texel(logic [11:0] gx, logic [11:0] gy);
        logic [11:0] ex, ey;
        if (want_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected texel x=%0d y=%0d", gx, gy);
            return;
        end
        ex = want_x.pop_front();
        ey = want_y.pop_front();
        if (gx !== ex || gy !== ey) begin
            mismatches++;
            if (mismatches <= 10)
                $display("texel mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                         ex, ey, gx, gy);
        end
    endfunction

    function int pending();
        return want_x.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [15:0] i_depth_frac = 0;
    logic [15:0] i_lateral_frac = 0;
    logic        o_strobe;
    logic [11:0] o_tex_x, o_tex_y;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [23:0] i_cfg_data = 0;

    floor_map_board board = new();
    int idle_pct = 0;

    perspective_floor_texcoord_core DUT (.*);

    initial forever #6 i_clk = ~i_clk;

    // accepted beats and results are both taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_beat(i_depth_frac, i_lateral_frac);
            if (o_strobe) board.check_texel(o_tex_x, o_tex_y);
        end
    end

    task automatic send_beat(logic [15:0] v, logic [15:0] u);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            i_depth_frac <= 16'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_depth_frac <= v;
        i_lateral_frac <= u;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [23:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        board.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [23:0] cx, logic [23:0] cy, logic [23:0] hd,
                             logic [23:0] nd, logic [23:0] tw, logic [23:0] th);
        drain();
        write_reg(REG_CAM_X, cx);
        write_reg(REG_CAM_Y, cy);
        write_reg(REG_HEADING, hd);
        write_reg(REG_NEAR_DEPTH, nd);
        write_reg(REG_TEX_WIDTH, tw);
        write_reg(REG_TEX_HEIGHT, th);
        write_reg(REG_SPARE_A, 24'($urandom));
        write_reg(REG_SPARE_B, 24'($urandom));
        i_cfg_we <= 1'b0;
        // heading passes r_heading and then r_sin/r_cos before it is used
        repeat (3) @(posedge i_clk);
    endtask

    task automatic corner_beats();
        send_beat(16'd0, 16'd0);
        send_beat(16'hFFFF, 16'hFFFF);
        send_beat(16'd0, 16'hFFFF);
        send_beat(16'hFFFF, 16'd0);
        send_beat(16'h8000, 16'h8000);
    endtask

    logic [23:0] tw, th;
    int phase_idle [6] = '{0, 57, 24, 57, 0, 24};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first, then corner settings
        corner_beats();
        write_all(24'h7FFFFF, 24'h800000, 24'd256, 24'd0, 24'd0, 24'd1);
        corner_beats();
        write_all(24'h800000, 24'h7FFFFF, 24'hFFFC01, 24'hFFFFFF, 24'd4096, 24'h1FFF);
        corner_beats();
        write_all(24'h001234, 24'hFFF000, 24'd1023, 24'd1, 24'd100, 24'd4095);
        corner_beats();
        write_all(24'd0, 24'd0, 24'd512, 24'hFF3456, 24'hFFE000, 24'd4097);
        corner_beats();

        for (int ph = 0; ph < 6; ph++) begin
            tw = $urandom_range(3, 0) == 0 ? 24'($urandom_range(8191, 0))
                                           : 24'(1 << $urandom_range(12, 4));
            th = $urandom_range(3, 0) == 0 ? 24'($urandom) : 24'($urandom_range(4096, 1));
            write_all(24'($urandom), 24'($urandom), 24'($urandom),
                      $urandom_range(1, 0) ? 24'($urandom_range(8000, 1)) : 24'($urandom),
                      tw, th);
            idle_pct = phase_idle[ph];
            for (int n = 0; n < 100; n++) begin
                if (ph == 2 && n == 50) drain();
                case ($urandom_range(9, 0))
                    0: send_beat(16'hFFFF, 16'($urandom));
                    1: send_beat(16'd0, $urandom_range(1, 0) ? 16'hFFFF : 16'd0);
                    default: send_beat(16'($urandom), 16'($urandom));
                endcase
            end
        end

        start <= 1'b0;
        for (int t = 0; t < 10000 && board.pending() != 0; t++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule
